[sv/mbps_pkg.sv]
package mbps_pkg;

    localparam int PATTERN_BYTES = 16;
    localparam int SIG_BYTES     = 16;
    localparam int OFFSET_BITS   = 32;
    localparam int DISP_BYTES    = (OFFSET_BITS + 7) / 8;
    localparam int DISP_BITS     = DISP_BYTES * 8;
    localparam int REL_MAX       = PATTERN_BYTES - DISP_BYTES;
    localparam int CMP_BYTES     = (PATTERN_BYTES < SIG_BYTES) ? PATTERN_BYTES : SIG_BYTES;
    localparam int ADDR_BITS     = 64;
    localparam int CFG_BITS      = 64;
    localparam int SEEN_BITS     = 32;
    localparam int REL_BITS      = 4;

    typedef enum logic [2:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_CARE_MASK    = 3'd2,
        REG_REL_OFFSET   = 3'd3,
        REG_BASE_ADDRESS = 3'd4
    } cfg_reg_t;

endpackage

[sv/masked_byte_pattern_scan_core.sv]
// Scans a byte stream for a 16-byte signature with per-byte wildcards (care_mask bit
// clear = wildcard). One byte is taken every cycle while s_tready is high; s_tlast
// closes a scan. The window of the previous 16 bytes is compared as each byte arrives,
// so a match is seen only when a further byte follows it. The first match produces one
// request with m_tuser = 1 and m_tdata = base_address + match offset, or, with
// rel_offset nonzero, that address plus rel_offset + 4 + the signed 32-bit little-endian
// displacement read from the window at rel_offset (clamped to 12). Further bytes are
// ignored until s_tlast. A scan ending without a match produces one request with
// m_tuser = 0 and m_tdata = 0. Stage 1 registers compare/partial sums; the output register
// does the final 64-bit add and decouples back-pressure. Registers are written through
// cfg_wr_en/cfg_index/cfg_wdata while the block is idle; the user must see to it (unchecked).
module masked_byte_pattern_scan_core
    import mbps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_index,
    input  logic [CFG_BITS-1:0]  cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // data_byte
    input  logic                 s_tlast,   // last_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [ADDR_BITS-1:0] m_tdata,   // address
    output logic                 m_tuser    // found
);

    logic [ADDR_BITS-1:0] pattern_low_reg;
    logic [ADDR_BITS-1:0] pattern_high_reg;
    logic [SIG_BYTES-1:0] care_mask_reg;
    logic [REL_BITS-1:0]  rel_offset_reg;
    logic [ADDR_BITS-1:0] base_address_reg;

    logic [7:0]           window_reg [PATTERN_BYTES];
    logic [SEEN_BITS-1:0] seen_reg;
    logic                 reported_reg;

    logic                 p1_valid_reg;
    logic                 p1_found_reg;
    logic [ADDR_BITS-1:0] p1_addr_reg;
    logic [DISP_BITS-1:0] p1_disp_reg;

    logic                 out_valid_reg;
    logic                 out_found_reg;
    logic [ADDR_BITS-1:0] out_addr_reg;

    logic [2*ADDR_BITS-1:0]   sig_flat;
    logic [PATTERN_BYTES*8-1:0] win_flat;
    logic                 win_match;
    logic                 match_now;
    logic                 emit;
    logic                 accept;
    logic                 out_free;
    logic                 p1_move;
    logic [REL_BITS-1:0]  rel_sat;
    logic [DISP_BITS-1:0] disp_raw;
    logic [DISP_BITS-1:0] disp_sum;
    logic [ADDR_BITS-1:0] off;

    assign sig_flat = {pattern_high_reg, pattern_low_reg};

    always_comb begin
        for (int i = 0; i < PATTERN_BYTES; i++) begin
            win_flat[i*8 +: 8] = window_reg[i];
        end
    end

    always_comb begin
        win_match = 1'b1;
        for (int i = 0; i < CMP_BYTES; i++) begin
            if (care_mask_reg[i] && (window_reg[i] != sig_flat[i*8 +: 8])) begin
                win_match = 1'b0;
            end
        end
    end

    assign match_now = !reported_reg && (seen_reg >= SEEN_BITS'(PATTERN_BYTES)) && win_match;
    assign emit      = match_now || (s_tlast && !reported_reg);

    assign rel_sat  = (rel_offset_reg > REL_BITS'(REL_MAX)) ? REL_BITS'(REL_MAX) : rel_offset_reg;
    assign disp_raw = win_flat[rel_sat*8 +: DISP_BITS];
    assign disp_sum = disp_raw + DISP_BITS'(rel_sat) + DISP_BITS'(4);
    assign off      = ADDR_BITS'(seen_reg - SEEN_BITS'(PATTERN_BYTES));

    assign out_free = !out_valid_reg || m_tready;
    assign p1_move  = p1_valid_reg && out_free;
    assign s_tready = !p1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_addr_reg;
    assign m_tuser  = out_found_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            care_mask_reg    <= '0;
            rel_offset_reg   <= '0;
            base_address_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PATTERN_LOW:  pattern_low_reg  <= cfg_wdata;
                REG_PATTERN_HIGH: pattern_high_reg <= cfg_wdata;
                REG_CARE_MASK:    care_mask_reg    <= cfg_wdata[SIG_BYTES-1:0];
                REG_REL_OFFSET:   rel_offset_reg   <= cfg_wdata[REL_BITS-1:0];
                REG_BASE_ADDRESS: base_address_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PATTERN_BYTES; i++) begin
                window_reg[i] <= '0;
            end
            seen_reg     <= '0;
            reported_reg <= 1'b0;
        end else if (accept) begin
            if (s_tlast) begin
                for (int i = 0; i < PATTERN_BYTES; i++) begin
                    window_reg[i] <= '0;
                end
                seen_reg     <= '0;
                reported_reg <= 1'b0;
            end else if (match_now) begin
                reported_reg <= 1'b1;
            end else if (!reported_reg) begin
                for (int i = 0; i < PATTERN_BYTES - 1; i++) begin
                    window_reg[i] <= window_reg[i+1];
                end
                window_reg[PATTERN_BYTES-1] <= s_tdata;
                if (seen_reg != '1) begin
                    seen_reg <= seen_reg + SEEN_BITS'(1);
                end
            end
        end
    end

    // stage 1: match decision, base + offset and displacement in parallel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            p1_valid_reg <= accept && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            p1_found_reg <= match_now;
            p1_addr_reg  <= match_now ? (base_address_reg + off) : '0;
            p1_disp_reg  <= (match_now && (rel_offset_reg != '0)) ? disp_sum : '0;
        end
    end

    // stage 2: final address into the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_move) begin
            out_found_reg <= p1_found_reg;
            out_addr_reg  <= p1_addr_reg
                           + {{(ADDR_BITS-DISP_BITS){p1_disp_reg[DISP_BITS-1]}}, p1_disp_reg};
        end
    end

endmodule
